[rtl/msep_pkg.sv]
// Shared types and constants for the sequence event parser.
// No dependencies; imported by msep_parse and the top level.
package msep_pkg;

  // file layout
  localparam int unsigned HEADER_BYTES     = 15;
  localparam int unsigned VARLEN_MAX_BYTES = 4;

  // header byte positions holding the tempo and the bars byte
  localparam logic [3:0] HDR_TEMPO_FIRST = 4'(HEADER_BYTES - 5);
  localparam logic [3:0] HDR_TEMPO_LAST  = 4'(HEADER_BYTES - 3);
  localparam logic [3:0] HDR_BARS        = 4'(HEADER_BYTES - 2);
  localparam logic [3:0] HDR_LAST        = 4'(HEADER_BYTES - 1);
  localparam logic [2:0] VARLEN_LAST     = 3'(VARLEN_MAX_BYTES);

  // parse phases
  localparam logic [3:0] PH_HEADER    = 4'd0;
  localparam logic [3:0] PH_DELTA     = 4'd1;
  localparam logic [3:0] PH_STATUS    = 4'd2;
  localparam logic [3:0] PH_NOTE_KEY  = 4'd3;
  localparam logic [3:0] PH_NOTE_VEL  = 4'd4;
  localparam logic [3:0] PH_PROG      = 4'd5;
  localparam logic [3:0] PH_META_CMD  = 4'd6;
  localparam logic [3:0] PH_META_LEN  = 4'd7;
  localparam logic [3:0] PH_SKIP      = 4'd8;
  localparam logic [3:0] PH_SYSEX_LEN = 4'd9;

  // status and meta codes
  localparam logic [7:0] STATUS_META   = 8'hff;
  localparam logic [7:0] META_EOT      = 8'h2f;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_PRES = 4'ha;
  localparam logic [3:0] NIB_CTRL      = 4'hb;
  localparam logic [3:0] NIB_PROG      = 4'hc;
  localparam logic [3:0] NIB_CHAN_PRES = 4'hd;
  localparam logic [3:0] NIB_BEND      = 4'he;

  // event kinds
  typedef enum logic [2:0] {
    EV_NOTE_ON  = 3'd0,
    EV_NOTE_OFF = 3'd1,
    EV_PROGRAM  = 3'd2,
    EV_END      = 3'd3,
    EV_HEADER   = 3'd4,
    EV_ERROR    = 3'd5
  } event_kind_e;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] event_time;
    logic [3:0]  channel;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [7:0]  program_res;
    logic [23:0] tempo_us;
    logic [7:0]  bars;
  } out_item_t;

endpackage

[rtl/msep_parse.sv]
// Parser state registers and the combinational next-state / result logic.
// Depends on msep_pkg.
module msep_parse import msep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  typedef struct packed {
    logic [3:0]  phase;
    logic        set_skip;
    logic [27:0] skip;
    logic        vreset;
  } disp_t;

  // state registers
  logic [3:0]  phase_q, phase_d;
  logic [3:0]  hcount_q, hcount_d;
  logic [23:0] tempo_q, tempo_d;
  logic [7:0]  bars_q, bars_d;
  logic [7:0]  running_q, running_d;
  logic [31:0] time_q, time_d;
  logic [27:0] vacc_q, vacc_d;
  logic [2:0]  vcnt_q, vcnt_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  first_q, first_d;
  logic [27:0] skip_q, skip_d;
  logic        fin_q, fin_d;

  // state as seen by this byte (restart applied)
  logic [3:0]  cur_phase;
  logic [3:0]  cur_hcount;
  logic [23:0] cur_tempo;
  logic [7:0]  cur_bars;
  logic [7:0]  cur_running;
  logic [31:0] cur_time;
  logic [27:0] cur_vacc;
  logic [2:0]  cur_vcnt;
  logic [7:0]  cur_status;
  logic [7:0]  cur_first;
  logic [27:0] cur_skip;
  logic        cur_fin;

  // working state handed to the data-byte phases
  logic [3:0]  wk_phase;
  logic [7:0]  wk_status;
  logic [27:0] wk_skip;
  logic [27:0] wk_vacc;
  logic [2:0]  wk_vcnt;

  logic [7:0]  b;
  logic [7:0]  st_sel;
  disp_t       disp;
  logic [27:0] vacc_cur_new, vacc_wk_new;
  logic [2:0]  vcnt_cur_new, vcnt_wk_new;
  logic        vdone_cur, vdone_wk;
  logic [27:0] skip_dec;
  logic [27:0] skip_n;
  logic        do_data;
  logic        do_skip;

  // decode a status byte into the phase it opens
  function automatic disp_t dispatch(input logic [7:0] st);
    disp_t d;
    d = '0;
    if (st == STATUS_META) begin
      d.phase = PH_META_CMD;
    end else begin
      case (st[7:4])
        NIB_NOTE_OFF, NIB_NOTE_ON: d.phase = PH_NOTE_KEY;
        NIB_PROG:                  d.phase = PH_PROG;
        NIB_POLY_PRES, NIB_CTRL, NIB_BEND: begin
          d.phase    = PH_SKIP;
          d.set_skip = 1'b1;
          d.skip     = 28'd2;
        end
        NIB_CHAN_PRES: begin
          d.phase    = PH_SKIP;
          d.set_skip = 1'b1;
          d.skip     = 28'd1;
        end
        default: begin
          d.phase  = PH_SYSEX_LEN;
          d.vreset = 1'b1;
        end
      endcase
    end
    return d;
  endfunction

  assign b = item_i.data_byte;

  // restart puts the parser back to its reset state before the byte
  always_comb begin
    if (item_i.restart) begin
      cur_phase   = PH_HEADER;
      cur_hcount  = '0;
      cur_tempo   = '0;
      cur_bars    = '0;
      cur_running = '0;
      cur_time    = '0;
      cur_vacc    = '0;
      cur_vcnt    = '0;
      cur_status  = '0;
      cur_first   = '0;
      cur_skip    = '0;
      cur_fin     = 1'b0;
    end else begin
      cur_phase   = phase_q;
      cur_hcount  = hcount_q;
      cur_tempo   = tempo_q;
      cur_bars    = bars_q;
      cur_running = running_q;
      cur_time    = time_q;
      cur_vacc    = vacc_q;
      cur_vcnt    = vcnt_q;
      cur_status  = status_q;
      cur_first   = first_q;
      cur_skip    = skip_q;
      cur_fin     = fin_q;
    end
  end

  // status decode: a data byte in status position reuses running status
  assign st_sel = b[7] ? b : cur_running;
  assign disp   = dispatch(st_sel);

  always_comb begin
    if (cur_phase == PH_STATUS) begin
      wk_phase  = disp.phase;
      wk_status = st_sel;
      wk_skip   = disp.set_skip ? disp.skip : cur_skip;
      wk_vacc   = disp.vreset ? '0 : cur_vacc;
      wk_vcnt   = disp.vreset ? '0 : cur_vcnt;
    end else begin
      wk_phase  = cur_phase;
      wk_status = cur_status;
      wk_skip   = cur_skip;
      wk_vacc   = cur_vacc;
      wk_vcnt   = cur_vcnt;
    end
  end

  // variable-length accumulation for delta and sysex length
  assign vacc_cur_new = {cur_vacc[20:0], b[6:0]};
  assign vcnt_cur_new = cur_vcnt + 3'd1;
  assign vdone_cur    = !b[7] || (vcnt_cur_new >= VARLEN_LAST);
  assign vacc_wk_new  = {wk_vacc[20:0], b[6:0]};
  assign vcnt_wk_new  = wk_vcnt + 3'd1;
  assign vdone_wk     = !b[7] || (vcnt_wk_new >= VARLEN_LAST);
  assign skip_dec     = wk_skip - 28'd1;

  // next state and result
  always_comb begin
    phase_d   = cur_phase;
    hcount_d  = cur_hcount;
    tempo_d   = cur_tempo;
    bars_d    = cur_bars;
    running_d = cur_running;
    time_d    = cur_time;
    vacc_d    = cur_vacc;
    vcnt_d    = cur_vcnt;
    status_d  = cur_status;
    first_d   = cur_first;
    skip_d    = cur_skip;
    fin_d     = cur_fin;
    do_data   = 1'b0;
    do_skip   = 1'b0;
    skip_n    = '0;
    res_valid_o       = 1'b0;
    res_o             = '0;
    res_o.event_time  = cur_time;

    if (!cur_fin) begin
      case (cur_phase)
        PH_HEADER: begin
          if (cur_hcount >= HDR_TEMPO_FIRST && cur_hcount <= HDR_TEMPO_LAST) begin
            tempo_d = {cur_tempo[15:0], b};
          end else if (cur_hcount == HDR_BARS) begin
            bars_d = b;
          end
          if (cur_hcount >= HDR_LAST) begin
            hcount_d = '0;
            vacc_d   = '0;
            vcnt_d   = '0;
            phase_d  = PH_DELTA;
            res_valid_o      = 1'b1;
            res_o.event_kind = EV_HEADER;
            res_o.tempo_us   = tempo_d;
            res_o.bars       = bars_d;
          end else begin
            hcount_d = cur_hcount + 4'd1;
          end
        end
        PH_DELTA: begin
          vacc_d = vacc_cur_new;
          vcnt_d = vcnt_cur_new;
          if (vdone_cur) begin
            time_d  = cur_time + {4'b0, vacc_cur_new};
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            running_d = b;
            phase_d   = wk_phase;
            status_d  = wk_status;
            skip_d    = wk_skip;
            vacc_d    = wk_vacc;
            vcnt_d    = wk_vcnt;
          end else if (cur_running == 8'd0) begin
            fin_d            = 1'b1;
            res_valid_o      = 1'b1;
            res_o.event_kind = EV_ERROR;
          end else begin
            do_data = 1'b1;
          end
        end
        default: do_data = 1'b1;
      endcase
    end

    // data-byte phases
    if (do_data) begin
      phase_d  = wk_phase;
      status_d = wk_status;
      skip_d   = wk_skip;
      vacc_d   = wk_vacc;
      vcnt_d   = wk_vcnt;
      case (wk_phase)
        PH_NOTE_KEY: begin
          first_d = b;
          phase_d = PH_NOTE_VEL;
        end
        PH_NOTE_VEL: begin
          vacc_d  = '0;
          vcnt_d  = '0;
          phase_d = PH_DELTA;
          res_valid_o       = 1'b1;
          res_o.event_kind  = (wk_status[7:4] == NIB_NOTE_ON && b != 8'd0) ?
                              EV_NOTE_ON : EV_NOTE_OFF;
          res_o.channel     = wk_status[3:0];
          res_o.note_number = cur_first;
          res_o.velocity    = b;
        end
        PH_PROG: begin
          vacc_d  = '0;
          vcnt_d  = '0;
          phase_d = PH_DELTA;
          res_valid_o       = 1'b1;
          res_o.event_kind  = EV_PROGRAM;
          res_o.channel     = wk_status[3:0];
          res_o.program_res = b;
        end
        PH_META_CMD: begin
          first_d = b;
          phase_d = PH_META_LEN;
        end
        PH_META_LEN: begin
          if (cur_first == META_EOT) begin
            fin_d            = 1'b1;
            res_valid_o      = 1'b1;
            res_o.event_kind = EV_END;
          end else begin
            do_skip = 1'b1;
            skip_n  = (cur_first == META_TEMPO) ? 28'd3 : {20'b0, b};
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 28'd0) begin
            vacc_d  = '0;
            vcnt_d  = '0;
            phase_d = PH_DELTA;
          end
        end
        PH_SYSEX_LEN: begin
          vacc_d = vacc_wk_new;
          vcnt_d = vcnt_wk_new;
          if (vdone_wk) begin
            do_skip = 1'b1;
            skip_n  = vacc_wk_new;
          end
        end
        default: begin
          vacc_d  = '0;
          vcnt_d  = '0;
          phase_d = PH_DELTA;
        end
      endcase
    end

    // skip a counted run of bytes, straight to the next delta if empty
    if (do_skip) begin
      skip_d = skip_n;
      if (skip_n == 28'd0) begin
        vacc_d  = '0;
        vcnt_d  = '0;
        phase_d = PH_DELTA;
      end else begin
        phase_d = PH_SKIP;
      end
    end
  end

  // state update once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hcount_q  <= '0;
      tempo_q   <= '0;
      bars_q    <= '0;
      running_q <= '0;
      time_q    <= '0;
      vacc_q    <= '0;
      vcnt_q    <= '0;
      status_q  <= '0;
      first_q   <= '0;
      skip_q    <= '0;
      fin_q     <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hcount_q  <= hcount_d;
      tempo_q   <= tempo_d;
      bars_q    <= bars_d;
      running_q <= running_d;
      time_q    <= time_d;
      vacc_q    <= vacc_d;
      vcnt_q    <= vcnt_d;
      status_q  <= status_d;
      first_q   <= first_d;
      skip_q    <= skip_d;
      fin_q     <= fin_d;
    end
  end

endmodule

[rtl/midi_sequence_event_parser_core.sv]
// Top level of the sequence event parser: input register, parser, result register.
// Depends on msep_pkg and msep_parse.

// Takes one file byte per transaction and returns at most one event per byte.
// A new byte is accepted every cycle while results are taken; a byte is
// parsed in the cycle after it is registered, and its event is written to the
// result register at the edge that ends that cycle. All parser state updates
// at that same edge. A stall on a waiting result holds the registered byte
// and stalls the input in the same cycle. Setting restart with a byte resets
// the parser and makes that byte the first header byte.
module midi_sequence_event_parser_core import msep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;
  logic      advance;
  logic      fire;
  logic      res_valid;
  out_item_t res;

  // the result register can take a new value
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // parser
  msep_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fire && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
